>>> src/rtp_pkg.sv
// Shared types, constants and register codes for the touch position reader.
package rtp_pkg;

    localparam int SAMPLES  = 10;
    localparam int DEBOUNCE = 50;
    localparam int ADC_BITS = 12;

    localparam int RAW_W  = 12;
    localparam int RES_W  = 16;
    localparam int CNT_W  = 4;
    localparam int SUM_W  = 16;
    localparam int TIME_W = 32;

    localparam int DIV_NUM_W  = RAW_W + RES_W;
    localparam int DIV_DEN_W  = RAW_W;
    localparam int DIV_STEP_W = $clog2(DIV_NUM_W + 1);

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 40;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [RAW_W-1:0] RAW_MASK        = RAW_W'((1 << ADC_BITS) - 1);
    localparam logic [RES_W-1:0] NOT_PRESSED_POS = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_END    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_START  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_END    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RES_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RES_Y    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PRESSURE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_Y = 3'd7;

    typedef struct packed {
        logic [RAW_W-1:0] x_start;
        logic [RAW_W-1:0] x_end;
        logic [RAW_W-1:0] y_start;
        logic [RAW_W-1:0] y_end;
        logic [RES_W-1:0] res_x;
        logic [RES_W-1:0] res_y;
        logic [RAW_W-1:0] pressure_limit;
        logic             invert_y;
    } cfg_t;

    typedef struct packed {
        logic              func;
        logic              touch_detected;
        logic [RAW_W-1:0]  raw_x;
        logic [RAW_W-1:0]  raw_y;
        logic [RAW_W-1:0]  raw_z;
        logic [TIME_W-1:0] now_ms;
    } item_t;

    typedef struct packed {
        logic             pressed;
        logic [RES_W-1:0] pos_x;
        logic [RES_W-1:0] pos_y;
        logic [CNT_W-1:0] samples_used;
    } result_t;

    typedef enum logic [1:0] {
        SEL_AVG_X,
        SEL_AVG_Y,
        SEL_MAP_X,
        SEL_MAP_Y
    } div_sel_t;

    typedef struct packed {
        logic     accept;
        logic     div_start;
        logic     div_store;
        div_sel_t div_sel;
        logic     mul_load;
        logic     mul_y;
        logic     emit;
    } dp_cmd_t;

    typedef struct packed {
        logic gives_np;
        logic gives_fin;
        logic div_done;
    } dp_status_t;

endpackage

>>> src/rtp_div.sv
// Restoring divider, one quotient bit per cycle, short mode for 16-bit dividends.
module rtp_div
    import rtp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic                 short_op,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quo
);

    localparam int SHORT_PAD = DIV_NUM_W - SUM_W;

    logic [DIV_STEP_W-1:0] step_reg;
    logic                  done_reg;
    logic [DIV_DEN_W-1:0]  rem_reg;
    logic [DIV_DEN_W-1:0]  den_reg;
    logic [DIV_NUM_W-1:0]  quo_reg;

    logic [DIV_DEN_W:0]    rem_sh;
    logic                  fits;
    logic [DIV_DEN_W-1:0]  rem_next;

    always_comb begin
        rem_sh   = {rem_reg, quo_reg[DIV_NUM_W-1]};
        fits     = rem_sh >= {1'b0, den_reg};
        rem_next = fits ? DIV_DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DIV_DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            step_reg <= short_op ? DIV_STEP_W'(SUM_W) : DIV_STEP_W'(DIV_NUM_W);
            done_reg <= 1'b0;
        end else if (step_reg != '0) begin
            step_reg <= step_reg - 1'b1;
            done_reg <= step_reg == DIV_STEP_W'(1);
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            den_reg <= den;
            // short mode: dividend left-aligned so the quotient lands in the low bits
            quo_reg <= short_op ? {num[SUM_W-1:0], SHORT_PAD'(0)} : num;
        end else if (step_reg != '0) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

>>> src/rtp_dp.sv
// Datapath: press debounce, sample sums, averaging and window-to-pixel mapping.
module rtp_dp
    import rtp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  item_t      item,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output result_t    result
);

    logic              latched_reg;
    logic              active_reg;
    logic [TIME_W-1:0] start_reg;
    logic              sampling_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SUM_W-1:0]  sum_x_reg;
    logic [SUM_W-1:0]  sum_y_reg;

    logic [SUM_W-1:0]     fin_x_reg;
    logic [SUM_W-1:0]     fin_y_reg;
    logic [CNT_W-1:0]     fin_cnt_reg;
    logic [RAW_W-1:0]     avg_x_reg;
    logic [RAW_W-1:0]     avg_y_reg;
    logic [DIV_NUM_W-1:0] prod_reg;
    result_t              res_reg;

    // press check
    logic              hard;
    logic [TIME_W-1:0] start_eff;
    logic [TIME_W-1:0] elapsed;
    logic              latched_next;
    logic              active_next;
    logic [TIME_W-1:0] start_next;
    logic              pressed_now;

    // sampling
    logic [SUM_W-1:0] add_x;
    logic [SUM_W-1:0] add_y;
    logic [CNT_W-1:0] cnt_inc;
    logic             run_full;

    // mapping
    logic                 x_empty;
    logic                 y_empty;
    logic [RAW_W-1:0]     m_raw;
    logic [RAW_W-1:0]     m_lo;
    logic [RAW_W-1:0]     m_hi;
    logic [RES_W-1:0]     m_res;
    logic [RAW_W-1:0]     m_clamp;
    logic [RAW_W-1:0]     m_diff;
    logic [RES_W-1:0]     py;

    logic                 div_short;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;

    always_comb begin
        hard         = item.raw_z <= cfg.pressure_limit;
        start_eff    = active_reg ? start_reg : item.now_ms;
        elapsed      = item.now_ms - start_eff;
        latched_next = latched_reg;
        active_next  = active_reg;
        start_next   = start_reg;
        if (item.touch_detected) begin
            priority if (!latched_reg && hard) begin
                start_next  = start_eff;
                active_next = 1'b1;
                if (elapsed >= TIME_W'(DEBOUNCE)) begin
                    latched_next = 1'b1;
                    active_next  = 1'b0;
                end
            end else if (latched_reg && !hard) begin
                latched_next = 1'b0;
            end else begin
                active_next = 1'b0;
            end
        end
        pressed_now = item.touch_detected && latched_next;
    end

    always_comb begin
        add_x    = sum_x_reg + SUM_W'(item.raw_x & RAW_MASK);
        add_y    = sum_y_reg + SUM_W'(item.raw_y & RAW_MASK);
        cnt_inc  = count_reg + 1'b1;
        run_full = cnt_inc >= CNT_W'(SAMPLES);
    end

    assign status.gives_np  = !item.func && !pressed_now;
    assign status.gives_fin = item.func && sampling_reg && (!item.touch_detected || run_full);
    assign status.div_done  = div_done;

    // run state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latched_reg  <= 1'b0;
            active_reg   <= 1'b0;
            start_reg    <= '0;
            sampling_reg <= 1'b0;
            count_reg    <= '0;
            sum_x_reg    <= '0;
            sum_y_reg    <= '0;
        end else if (cmd.accept) begin
            if (!item.func) begin
                latched_reg  <= latched_next;
                active_reg   <= active_next;
                start_reg    <= start_next;
                sampling_reg <= pressed_now;
                count_reg    <= '0;
                sum_x_reg    <= '0;
                sum_y_reg    <= '0;
            end else if (sampling_reg) begin
                if (!item.touch_detected || run_full) begin
                    sampling_reg <= 1'b0;
                    count_reg    <= '0;
                    sum_x_reg    <= '0;
                    sum_y_reg    <= '0;
                end else begin
                    count_reg <= cnt_inc;
                    sum_x_reg <= add_x;
                    sum_y_reg <= add_y;
                end
            end
        end
    end

    // closing sums, taken when a run ends
    always_ff @(posedge aclk) begin
        if (cmd.accept && status.gives_fin) begin
            if (!item.touch_detected) begin
                fin_x_reg   <= sum_x_reg;
                fin_y_reg   <= sum_y_reg;
                fin_cnt_reg <= count_reg;
            end else begin
                fin_x_reg   <= add_x;
                fin_y_reg   <= add_y;
                fin_cnt_reg <= cnt_inc;
            end
        end
    end

    always_comb begin
        x_empty = cfg.x_end <= cfg.x_start;
        y_empty = cfg.y_end <= cfg.y_start;
        if (cmd.mul_y) begin
            m_raw = avg_y_reg;
            m_lo  = cfg.y_start;
            m_hi  = cfg.y_end;
            m_res = cfg.res_y;
        end else begin
            m_raw = avg_x_reg;
            m_lo  = cfg.x_start;
            m_hi  = cfg.x_end;
            m_res = cfg.res_x;
        end
        priority if (m_raw < m_lo) begin
            m_clamp = m_lo;
        end else if (m_raw > m_hi) begin
            m_clamp = m_hi;
        end else begin
            m_clamp = m_raw;
        end
        m_diff = m_clamp - m_lo;
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_load) begin
            prod_reg <= DIV_NUM_W'(m_diff) * DIV_NUM_W'(m_res);
        end
    end

    always_comb begin
        unique case (cmd.div_sel)
            SEL_AVG_X: begin
                div_short = 1'b1;
                div_num   = DIV_NUM_W'(fin_x_reg);
                div_den   = DIV_DEN_W'(fin_cnt_reg);
            end
            SEL_AVG_Y: begin
                div_short = 1'b1;
                div_num   = DIV_NUM_W'(fin_y_reg);
                div_den   = DIV_DEN_W'(fin_cnt_reg);
            end
            SEL_MAP_X: begin
                div_short = 1'b0;
                div_num   = prod_reg;
                div_den   = cfg.x_end - cfg.x_start;
            end
            SEL_MAP_Y: begin
                div_short = 1'b0;
                div_num   = prod_reg;
                div_den   = cfg.y_end - cfg.y_start;
            end
            default: begin
                div_short = 1'b0;
                div_num   = prod_reg;
                div_den   = cfg.x_end - cfg.x_start;
            end
        endcase
        py = y_empty ? '0 : div_quo[RES_W-1:0];
    end

    rtp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .short_op (div_short),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quo      (div_quo)
    );

    // result assembly
    always_ff @(posedge aclk) begin
        if (cmd.accept && status.gives_np) begin
            res_reg.pressed      <= 1'b0;
            res_reg.pos_x        <= NOT_PRESSED_POS;
            res_reg.pos_y        <= NOT_PRESSED_POS;
            res_reg.samples_used <= '0;
        end else if (cmd.accept && status.gives_fin) begin
            res_reg.pressed      <= 1'b1;
            res_reg.samples_used <= item.touch_detected ? cnt_inc : count_reg;
        end else if (cmd.div_store) begin
            unique case (cmd.div_sel)
                SEL_AVG_X: avg_x_reg <= (fin_cnt_reg == '0) ? '0 : div_quo[RAW_W-1:0];
                SEL_AVG_Y: avg_y_reg <= (fin_cnt_reg == '0) ? '0 : div_quo[RAW_W-1:0];
                SEL_MAP_X: res_reg.pos_x <= x_empty ? '0 : div_quo[RES_W-1:0];
                SEL_MAP_Y: res_reg.pos_y <= cfg.invert_y ? cfg.res_y - py : py;
                default:   res_reg.pos_x <= res_reg.pos_x;
            endcase
        end
    end

    assign result = res_reg;

`ifndef ASSERT_OFF
    a_count_below_full: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg < CNT_W'(SAMPLES))
        else $error("sample count reached the run length without closing");

    a_idle_sums_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !sampling_reg |-> (count_reg == '0 && sum_x_reg == '0 && sum_y_reg == '0))
        else $error("sums left over outside a sampling run");

    a_latch_no_debounce: assert property (@(posedge aclk) disable iff (!aresetn)
        latched_reg |-> !active_reg)
        else $error("debounce timer running while press is latched");
`endif

endmodule

>>> src/rtp_ctrl.sv
// Controller: sequences item intake, the two averages, the two mappings and the result beat.
module rtp_ctrl
    import rtp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic       out_free,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       in_ready
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_AX_GO   = 4'd1;
    localparam logic [3:0] ST_AX_WAIT = 4'd2;
    localparam logic [3:0] ST_AY_GO   = 4'd3;
    localparam logic [3:0] ST_AY_WAIT = 4'd4;
    localparam logic [3:0] ST_MX_MUL  = 4'd5;
    localparam logic [3:0] ST_MX_GO   = 4'd6;
    localparam logic [3:0] ST_MX_WAIT = 4'd7;
    localparam logic [3:0] ST_MY_MUL  = 4'd8;
    localparam logic [3:0] ST_MY_GO   = 4'd9;
    localparam logic [3:0] ST_MY_WAIT = 4'd10;
    localparam logic [3:0] ST_EMIT    = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb begin
        cmd        = '0;
        cmd.div_sel = SEL_AVG_X;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.accept = 1'b1;
                    priority if (status.gives_np) begin
                        state_next = ST_EMIT;
                    end else if (status.gives_fin) begin
                        state_next = ST_AX_GO;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_AX_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_AX_WAIT;
            end
            ST_AX_WAIT: begin
                if (status.div_done) begin
                    cmd.div_store = 1'b1;
                    state_next    = ST_AY_GO;
                end
            end
            ST_AY_GO: begin
                cmd.div_sel   = SEL_AVG_Y;
                cmd.div_start = 1'b1;
                state_next    = ST_AY_WAIT;
            end
            ST_AY_WAIT: begin
                cmd.div_sel = SEL_AVG_Y;
                if (status.div_done) begin
                    cmd.div_store = 1'b1;
                    state_next    = ST_MX_MUL;
                end
            end
            ST_MX_MUL: begin
                cmd.mul_load = 1'b1;
                state_next   = ST_MX_GO;
            end
            ST_MX_GO: begin
                cmd.div_sel   = SEL_MAP_X;
                cmd.div_start = 1'b1;
                state_next    = ST_MX_WAIT;
            end
            ST_MX_WAIT: begin
                cmd.div_sel = SEL_MAP_X;
                if (status.div_done) begin
                    cmd.div_store = 1'b1;
                    state_next    = ST_MY_MUL;
                end
            end
            ST_MY_MUL: begin
                cmd.mul_load = 1'b1;
                cmd.mul_y    = 1'b1;
                state_next   = ST_MY_GO;
            end
            ST_MY_GO: begin
                cmd.div_sel   = SEL_MAP_Y;
                cmd.div_start = 1'b1;
                state_next    = ST_MY_WAIT;
            end
            ST_MY_WAIT: begin
                cmd.div_sel = SEL_MAP_Y;
                if (status.div_done) begin
                    cmd.div_store = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = state_reg == ST_IDLE;

endmodule

>>> src/resistive_touch_position_reader_core.sv
// Top level: stream ports, configuration registers, result register.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tuser: func; tdata: touch, raw_x, raw_y, raw_z, now_ms
//  m_*       out  m_tvalid/m_tready  tuser: pressed; tdata: pos_x, pos_y, samples_used
//  cfg_*     in   cfg_valid/cfg_ready index 0..7, data 16 bit (low bits used)
//
//  An item that gives no result keeps the controller idle; a not-pressed answer goes
//  straight to the result beat. A run's closing item uses the shared bit-serial divider:
//  two 16-step averages and two 28-step mappings run one after another.
//  Reset is synchronous, active low, and restores the register defaults.
//  A held result beat stalls the block only when the next result is ready to go out.
module resistive_touch_position_reader_core
    import rtp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // touch_detected, raw_x, raw_y, raw_z, now_ms
    input  logic                 s_tuser,   // func

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // pos_x, pos_y, samples_used
    output logic                 m_tuser,   // pressed

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    cfg_t       cfg_reg;
    item_t      item;
    dp_cmd_t    cmd;
    dp_status_t status;
    result_t    result;
    logic       out_free;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_start        <= RAW_W'(0);
            cfg_reg.x_end          <= RAW_W'(4095);
            cfg_reg.y_start        <= RAW_W'(0);
            cfg_reg.y_end          <= RAW_W'(4095);
            cfg_reg.res_x          <= RES_W'(480);
            cfg_reg.res_y          <= RES_W'(320);
            cfg_reg.pressure_limit <= RAW_W'(2048);
            cfg_reg.invert_y       <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_X_START:  cfg_reg.x_start        <= cfg_data[RAW_W-1:0];
                REG_X_END:    cfg_reg.x_end          <= cfg_data[RAW_W-1:0];
                REG_Y_START:  cfg_reg.y_start        <= cfg_data[RAW_W-1:0];
                REG_Y_END:    cfg_reg.y_end          <= cfg_data[RAW_W-1:0];
                REG_RES_X:    cfg_reg.res_x          <= cfg_data[RES_W-1:0];
                REG_RES_Y:    cfg_reg.res_y          <= cfg_data[RES_W-1:0];
                REG_PRESSURE: cfg_reg.pressure_limit <= cfg_data[RAW_W-1:0];
                REG_INVERT_Y: cfg_reg.invert_y       <= cfg_data[0];
                default:      cfg_reg.invert_y       <= cfg_reg.invert_y;
            endcase
        end
    end

    always_comb begin
        item.func           = s_tuser;
        item.touch_detected = s_tdata[0];
        item.raw_x          = s_tdata[12:1];
        item.raw_y          = s_tdata[24:13];
        item.raw_z          = s_tdata[36:25];
        item.now_ms         = s_tdata[68:37];
    end

    assign out_free = !m_tvalid_reg || m_tready;

    rtp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd),
        .in_ready (s_tready)
    );

    rtp_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .item    (item),
        .cmd     (cmd),
        .status  (status),
        .result  (result)
    );

    // result beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= M_TDATA_W'({result.samples_used, result.pos_y, result.pos_x});
            m_tuser_reg <= result.pressed;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef ASSERT_OFF
    a_np_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[31:0] == '1 && m_tdata[35:32] == '0))
        else $error("not-pressed beat without the no-touch position");
`endif

endmodule

>>> test/resistive_touch_position_reader_core_tb.sv
// Self-checking testbench for the touch position reader: stream driver, monitor and predictor.
module resistive_touch_position_reader_core_tb;
    import rtp_pkg::*;

    localparam int LIMIT_CYCLES  = 600000;
    localparam int SETTLE_CYCLES = 120;
    localparam int RANDOM_ITEMS  = 150;
    localparam int MAX_PRINTED   = 100;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    resistive_touch_position_reader_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // register copy, reset values
    cfg_t regs = '{x_start: 12'd0, x_end: 12'd4095, y_start: 12'd0, y_end: 12'd4095,
                   res_x: 16'd480, res_y: 16'd320, pressure_limit: 12'd2048,
                   invert_y: 1'b0};

    // press detector and sampling run state
    logic             latched     = 1'b0;
    logic             debouncing  = 1'b0;
    logic [31:0]      debounce_t0 = '0;
    logic             run_open    = 1'b0;
    logic [CNT_W-1:0] run_count   = '0;
    logic [SUM_W-1:0] run_sum_x   = '0;
    logic [SUM_W-1:0] run_sum_y   = '0;

    item_t   pending_items[$];
    result_t expected_positions[$];
    item_t   in_flight;
    int      src_gap     = 0;
    int      sink_hold   = 0;
    int      errors      = 0;
    int      cycle_count = 0;
    logic    quiet       = 1'b0;
    logic [31:0] clock_ms = 32'd1000;

    function automatic logic [15:0] map_axis(input logic [15:0] avg, input logic [11:0] lo,
                                             input logic [11:0] hi, input logic [15:0] res);
        longint unsigned v;
        if (hi <= lo) return '0;
        v = 64'(avg);
        if (v < 64'(lo)) v = 64'(lo);
        if (v > 64'(hi)) v = 64'(hi);
        return 16'(((v - 64'(lo)) * 64'(res)) / (64'(hi) - 64'(lo)));
    endfunction

    task automatic track_touch(input item_t it);
        result_t     r;
        logic        hard;
        logic [31:0] elapsed;
        logic [15:0] ax;
        logic [15:0] ay;
        if (it.func == 1'b0) begin
            run_open  = 1'b0;
            run_count = '0;
            run_sum_x = '0;
            run_sum_y = '0;
            if (it.touch_detected) begin
                hard = it.raw_z <= regs.pressure_limit;
                if (!latched && hard) begin
                    if (!debouncing) begin
                        debounce_t0 = it.now_ms;
                        debouncing  = 1'b1;
                    end
                    elapsed = it.now_ms - debounce_t0;
                    if (elapsed >= 32'(DEBOUNCE)) begin
                        latched    = 1'b1;
                        debouncing = 1'b0;
                    end
                end else if (latched && !hard) begin
                    latched = 1'b0;
                end else begin
                    debouncing = 1'b0;
                end
            end
            if (it.touch_detected && latched) begin
                run_open = 1'b1;
            end else begin
                r.pressed      = 1'b0;
                r.pos_x        = NOT_PRESSED_POS;
                r.pos_y        = NOT_PRESSED_POS;
                r.samples_used = '0;
                expected_positions.push_back(r);
            end
        end else if (run_open) begin
            if (it.touch_detected) begin
                run_sum_x = run_sum_x + SUM_W'(it.raw_x & RAW_MASK);
                run_sum_y = run_sum_y + SUM_W'(it.raw_y & RAW_MASK);
                run_count = run_count + 1'b1;
            end
            if (!it.touch_detected || run_count >= CNT_W'(SAMPLES)) begin
                ax = (run_count != '0) ? run_sum_x / SUM_W'(run_count) : 16'd0;
                ay = (run_count != '0) ? run_sum_y / SUM_W'(run_count) : 16'd0;
                r.pressed      = 1'b1;
                r.pos_x        = map_axis(ax, regs.x_start, regs.x_end, regs.res_x);
                r.pos_y        = map_axis(ay, regs.y_start, regs.y_end, regs.res_y);
                if (regs.invert_y) r.pos_y = regs.res_y - r.pos_y;
                r.samples_used = run_count;
                expected_positions.push_back(r);
                run_open  = 1'b0;
                run_count = '0;
                run_sum_x = '0;
                run_sum_y = '0;
            end
        end
    endtask

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        if (errors < MAX_PRINTED)
            $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic check_position(input result_t got);
        result_t want;
        if (expected_positions.size() == 0) begin
            flag_mismatch("unexpected beat, pos_x", got.pos_x, -1);
        end else begin
            want = expected_positions.pop_front();
            if (got.pressed !== want.pressed) flag_mismatch("pressed", got.pressed, want.pressed);
            if (got.pos_x !== want.pos_x) flag_mismatch("pos_x", got.pos_x, want.pos_x);
            if (got.pos_y !== want.pos_y) flag_mismatch("pos_y", got.pos_y, want.pos_y);
            if (got.samples_used !== want.samples_used)
                flag_mismatch("samples_used", got.samples_used, want.samples_used);
        end
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) track_touch(in_flight);
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    in_flight = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= in_flight.func;
                    s_tdata  <= {3'b000, in_flight.now_ms, in_flight.raw_z, in_flight.raw_y,
                                 in_flight.raw_x, in_flight.touch_detected};
                    if (!quiet && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 4);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                check_position('{pressed: m_tuser, pos_x: m_tdata[15:0], pos_y: m_tdata[31:16],
                                 samples_used: m_tdata[35:32]});
            if (sink_hold > 0) begin
                sink_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 4) == 0) sink_hold = $urandom_range(1, 4);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("resistive_touch_position_reader_core_tb: done, errors");
            $finish;
        end
    end

    function automatic item_t make_item(input logic func, input logic touch,
                                        input logic [11:0] x, input logic [11:0] y,
                                        input logic [11:0] z, input logic [31:0] now);
        item_t it;
        it.func           = func;
        it.touch_detected = touch;
        it.raw_x          = x;
        it.raw_y          = y;
        it.raw_z          = z;
        it.now_ms         = now;
        return it;
    endfunction

    function automatic logic [11:0] pick_raw(input logic [11:0] a, input logic [11:0] b);
        if ($urandom_range(0, 1) == 0) return 12'($urandom_range(0, 4095));
        return (a <= b) ? 12'($urandom_range(a, b)) : 12'($urandom_range(b, a));
    endfunction

    function automatic logic [11:0] pressing_z();
        if ($urandom_range(0, 9) == 0) return 12'($urandom_range(0, 4095));
        return 12'($urandom_range(0, regs.pressure_limit));
    endfunction

    function automatic logic [11:0] releasing_z();
        if (regs.pressure_limit == 12'd4095) return 12'($urandom_range(0, 4095));
        return 12'($urandom_range(regs.pressure_limit + 1, 4095));
    endfunction

    task automatic push_sample(input logic touch);
        pending_items.push_back(make_item(1'b1, touch, pick_raw(regs.x_start, regs.x_end),
                                          pick_raw(regs.y_start, regs.y_end),
                                          12'($urandom_range(0, 4095)), $urandom()));
    endtask

    task automatic push_random(input int n);
        int   made;
        int   k;
        int   checks;
        int   nsamp;
        logic func;
        made = 0;
        while (made < n) begin
            if ($urandom_range(0, 9) < 7) begin
                // press checks that usually latch, then a sampling run
                checks = $urandom_range(1, 3);
                for (k = 0; k < checks; k++) begin
                    clock_ms += (k == 0) ? $urandom_range(0, 120) : $urandom_range(20, 60);
                    pending_items.push_back(make_item(1'b0, 1'b1, 12'($urandom_range(0, 4095)),
                                                      12'($urandom_range(0, 4095)),
                                                      pressing_z(), clock_ms));
                    made++;
                end
                nsamp = $urandom_range(0, 11);
                for (k = 0; k < nsamp; k++) begin
                    push_sample(1'b1);
                    made++;
                end
                if ($urandom_range(0, 2) == 0) begin
                    push_sample(1'b0);
                    made++;
                end
                if ($urandom_range(0, 3) == 0) begin
                    clock_ms += $urandom_range(0, 30);
                    pending_items.push_back(make_item(1'b0, 1'b1, 12'($urandom_range(0, 4095)),
                                                      12'($urandom_range(0, 4095)),
                                                      releasing_z(), clock_ms));
                    made++;
                end
            end else begin
                func = 1'($urandom_range(0, 1));
                pending_items.push_back(make_item(func, 1'($urandom_range(0, 1)),
                                                  12'($urandom_range(0, 4095)),
                                                  12'($urandom_range(0, 4095)),
                                                  12'($urandom_range(0, 4095)), $urandom()));
                made++;
            end
        end
    endtask

    task automatic push_directed();
        int k;
        pending_items.push_back(make_item(1'b1, 1'b1, 12'hFFF, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF));
        pending_items.push_back(make_item(1'b0, 1'b0, 12'h000, 12'h000, 12'h000, 32'h0));
        pending_items.push_back(make_item(1'b0, 1'b1, 12'h000, 12'h000, 12'hFFF, 32'd1000));
        // debounce: start at 1000, not yet at 1049, latched at 1050
        pending_items.push_back(make_item(1'b0, 1'b1, 12'h000, 12'h000, 12'd0, 32'd1000));
        pending_items.push_back(make_item(1'b0, 1'b1, 12'h000, 12'h000, 12'd2048, 32'd1049));
        pending_items.push_back(make_item(1'b0, 1'b1, 12'h000, 12'h000, 12'd2048, 32'd1050));
        for (k = 0; k < SAMPLES; k++)
            pending_items.push_back(make_item(1'b1, 1'b1, k[0] ? 12'h000 : 12'hFFF,
                                              k[0] ? 12'hFFF : 12'h000, 12'h000, 32'd0));
        pending_items.push_back(make_item(1'b1, 1'b1, 12'd77, 12'd88, 12'd0, 32'd0));
        pending_items.push_back(make_item(1'b0, 1'b1, 12'h000, 12'h000, 12'd100, 32'd1100));
        pending_items.push_back(make_item(1'b1, 1'b1, 12'hFFF, 12'hFFF, 12'd0, 32'd0));
        // press check in the middle of a run restarts it
        pending_items.push_back(make_item(1'b0, 1'b1, 12'h000, 12'h000, 12'd5, 32'd1101));
        pending_items.push_back(make_item(1'b1, 1'b0, 12'hFFF, 12'hFFF, 12'd0, 32'd0));
        pending_items.push_back(make_item(1'b0, 1'b1, 12'h000, 12'h000, 12'hFFF, 32'd1102));
        // debounce across the millisecond counter wrap
        pending_items.push_back(make_item(1'b0, 1'b1, 12'h000, 12'h000, 12'd0, 32'hFFFF_FFF0));
        pending_items.push_back(make_item(1'b0, 1'b1, 12'h000, 12'h000, 12'd0, 32'h0000_0030));
        pending_items.push_back(make_item(1'b1, 1'b1, 12'd123, 12'd3000, 12'd0, 32'd0));
        pending_items.push_back(make_item(1'b1, 1'b0, 12'd0, 12'd0, 12'd0, 32'd0));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_X_START:  regs.x_start        = val[11:0];
            REG_X_END:    regs.x_end          = val[11:0];
            REG_Y_START:  regs.y_start        = val[11:0];
            REG_Y_END:    regs.y_end          = val[11:0];
            REG_RES_X:    regs.res_x          = val;
            REG_RES_Y:    regs.res_y          = val;
            REG_PRESSURE: regs.pressure_limit = val[11:0];
            REG_INVERT_Y: regs.invert_y       = val[0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input cfg_t c);
        write_reg(REG_X_START, 16'(c.x_start));
        write_reg(REG_X_END, 16'(c.x_end));
        write_reg(REG_Y_START, 16'(c.y_start));
        write_reg(REG_Y_END, 16'(c.y_end));
        write_reg(REG_RES_X, c.res_x);
        write_reg(REG_RES_Y, c.res_y);
        write_reg(REG_PRESSURE, 16'(c.pressure_limit));
        write_reg(REG_INVERT_Y, 16'(c.invert_y));
    endtask

    function automatic cfg_t random_regs();
        cfg_t c;
        c.x_start = 12'($urandom_range(0, 4095));
        c.x_end   = ($urandom_range(0, 3) != 0) ? 12'($urandom_range(c.x_start, 4095))
                                                : 12'($urandom_range(0, 4095));
        c.y_start = 12'($urandom_range(0, 4095));
        c.y_end   = ($urandom_range(0, 3) != 0) ? 12'($urandom_range(c.y_start, 4095))
                                                : 12'($urandom_range(0, 4095));
        c.res_x   = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 1023)) : 16'($urandom());
        c.res_y   = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 1023)) : 16'($urandom());
        c.pressure_limit = 12'($urandom_range(0, 4095));
        c.invert_y       = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // all items accepted, all results seen, then let a closing run finish
    task automatic settle();
        do @(posedge aclk);
        while (pending_items.size() != 0 || s_tvalid || expected_positions.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int p;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        push_directed();
        push_random(RANDOM_ITEMS);
        settle();

        program_regs('{x_start: 12'd0, x_end: 12'd4095, y_start: 12'd0, y_end: 12'd4095,
                       res_x: 16'hFFFF, res_y: 16'hFFFF, pressure_limit: 12'd4095,
                       invert_y: 1'b1});
        push_random(RANDOM_ITEMS);
        settle();

        // reversed X window, empty Y window, only zero pressure presses
        program_regs('{x_start: 12'd3000, x_end: 12'd1000, y_start: 12'd2000, y_end: 12'd2000,
                       res_x: 16'd0, res_y: 16'd12345, pressure_limit: 12'd0,
                       invert_y: 1'b1});
        clock_ms = 32'hFFFF_FF00;
        push_random(RANDOM_ITEMS);
        settle();

        for (p = 0; p < 4; p++) begin
            program_regs(random_regs());
            if (p == 3) quiet = 1'b1;
            push_random(RANDOM_ITEMS);
            settle();
        end

        if (errors == 0) begin
            $display("resistive_touch_position_reader_core_tb: done, clean");
        end else begin
            $display("resistive_touch_position_reader_core_tb: done, errors");
        end
        $finish;
    end

endmodule
